// ===== rtl/core/wildcard_byte_pattern_scanner_defines.svh =====
// Assertion macros for the wildcard byte pattern scanner checks.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WBPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wbps check failed");

// Consequent must hold in the cycle after the antecedent.
`define WBPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wbps check failed");

`endif

// ===== rtl/core/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scanner.
`default_nettype none
package wbps_pkg;

  localparam int unsigned PATTERN_BYTES = 16;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned ADDR_W        = 64;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_INDEX_W   = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_WILDCARD_MASK  = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_REGION_BASE    = 3'd4
  } reg_index_t;

  // Pattern setup seen by every cell; len is already clamped.
  typedef struct packed {
    logic [PATTERN_BYTES-1:0][7:0] pattern;
    logic [PATTERN_BYTES-1:0]      wild;
    logic [LEN_W-1:0]              len;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/wbps_cell.sv =====
// One window cell: holds one byte of the window and compares the byte entering it.
`default_nettype none
module wbps_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          shift_en,
  input  wire logic [7:0]    byte_in,
  input  wire wbps_pkg::cfg_t cfg,
  output logic      [7:0]    byte_out,
  output logic               hit
);

  localparam logic [6:0] POS = 7'(IDX);

  logic [6:0] len_ext;
  logic       active;
  logic [3:0] sel;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_out <= byte_in;
    end
  end

  // Cell at age IDX lines up with pattern byte len-1-IDX.
  assign len_ext = 7'(cfg.len);
  assign active  = len_ext > POS;
  assign sel     = 4'(len_ext - POS - 7'd1);
  assign hit     = !active || cfg.wild[sel] || (byte_in == cfg.pattern[sel]);

endmodule
`default_nettype wire

// ===== rtl/core/wbps_outq.sv =====
// Two-entry result queue between the match logic and the output channel.
`default_nettype none
module wbps_outq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire wbps_pkg::res_t push_data,
  input  wire logic           pop_stall,
  output logic                head_valid,
  output wbps_pkg::res_t      head,
  output logic                full
);

  logic [1:0]     cnt;
  logic [1:0]     cnt_next;
  wbps_pkg::res_t second;
  logic           pop;

  assign pop        = head_valid && !pop_stall;
  assign head_valid = cnt != 2'd0;
  assign full       = cnt == 2'd2;

  always_comb begin
    cnt_next = cnt;
    case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt == 2'd2) begin
      if (pop) begin
        head <= second;
      end
    end else if (push) begin
      if (cnt == 2'd0 || pop) begin
        head <= push_data;
      end else begin
        second <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wildcard_byte_pattern_scanner.sv =====
// Top level of the wildcard byte pattern scanner.
// Takes one region byte per cycle with no bubbles while in_stall is low; each
// result leaves from a registered queue head. A row of MAX_PATTERN cells
// holds the newest bytes and compares all window positions in the same cycle
// the byte is accepted. Results go through a two-entry queue, so in_stall rises
// only when two results are waiting on a stalled output. Pattern registers are
// written with cfg_write; pattern_length resets to 1, the others to 0.
`default_nettype none
module wildcard_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        data_byte,
  input  wire logic                              last_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   found,
  output logic      [wbps_pkg::ADDR_W-1:0]       match_address
);

  localparam logic [wbps_pkg::LEN_W-1:0] LEN_LIMIT =
    wbps_pkg::LEN_W'((MAX_PATTERN < wbps_pkg::PATTERN_BYTES) ?
                     MAX_PATTERN : wbps_pkg::PATTERN_BYTES);

  logic [63:0]                  pattern_low;
  logic [63:0]                  pattern_high;
  logic [15:0]                  wildcard_mask;
  logic [wbps_pkg::LEN_W-1:0]   pattern_length;
  logic [wbps_pkg::ADDR_W-1:0]  region_base;

  logic [COUNT_WIDTH-1:0]       byte_count;
  logic [COUNT_WIDTH-1:0]       count_next;
  logic [COUNT_WIDTH-1:0]       offset;
  logic                         match_reported;

  wbps_pkg::cfg_t               cfg;
  wbps_pkg::res_t               res;
  logic                         accept;
  logic                         counted;
  logic                         enough;
  logic                         match;
  logic                         push;
  logic [MAX_PATTERN-1:0]       hits;
  logic [7:0]                   win [MAX_PATTERN];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_mask  <= '0;
      pattern_length <= wbps_pkg::LEN_W'(1);
      region_base    <= '0;
    end else if (cfg_write) begin
      case (wbps_pkg::reg_index_t'(cfg_index))
        wbps_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        wbps_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        wbps_pkg::REG_WILDCARD_MASK:  wildcard_mask  <= cfg_data[15:0];
        wbps_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_REGION_BASE:    region_base    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.pattern = {pattern_high, pattern_low};
  assign cfg.wild    = wildcard_mask;
  assign cfg.len     = (pattern_length > LEN_LIMIT) ? LEN_LIMIT : pattern_length;

  assign accept = in_valid && !in_stall;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    wbps_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  ((k == 0) ? data_byte : win[(k == 0) ? 0 : k - 1]),
      .cfg      (cfg),
      .byte_out (win[k]),
      .hit      (hits[k])
    );
  end

  // Saturated counter stops both counting and testing.
  assign counted    = !(&byte_count);
  assign count_next = byte_count + COUNT_WIDTH'(1);
  assign enough     = count_next >= COUNT_WIDTH'(cfg.len);
  assign match      = counted && !match_reported && (cfg.len != '0) && enough && (&hits);
  assign offset     = count_next - COUNT_WIDTH'(cfg.len);

  always_comb begin
    res.found   = match;
    res.address = match ? (region_base + wbps_pkg::ADDR_W'(offset)) : '0;
  end

  assign push = accept && (match || (last_byte && !match_reported));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      match_reported <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count     <= '0;
        match_reported <= 1'b0;
      end else begin
        if (counted) begin
          byte_count <= count_next;
        end
        if (match) begin
          match_reported <= 1'b1;
        end
      end
    end
  end

  wbps_pkg::res_t head;

  wbps_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (res),
    .pop_stall  (out_stall),
    .head_valid (out_valid),
    .head       (head),
    .full       (in_stall)
  );

  assign found         = head.found;
  assign match_address = head.address;

endmodule
`default_nettype wire

// ===== rtl/core/wbps_checker.sv =====
// Port-level checks for the wildcard byte pattern scanner, bound to the top level.
`default_nettype none
`include "wildcard_byte_pattern_scanner_defines.svh"
module wbps_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              found,
  input wire logic [wbps_pkg::ADDR_W-1:0]       match_address
);

  `WBPS_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
  `WBPS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(found) && $stable(match_address))
  `WBPS_ASSERT_NOW(a_miss_zero_addr, out_valid && !found, match_address == '0)
  `WBPS_ASSERT_NOW(a_result_has_request, $rose(out_valid), $past(in_valid && !in_stall))
  `WBPS_ASSERT_NOW(a_stall_from_backpressure, $rose(in_stall), $past(out_valid && out_stall))

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .found         (found),
  .match_address (match_address)
);
`default_nettype wire

// ===== tb/sv/wildcard_byte_pattern_scanner_tb.sv =====
// Self-checking testbench for the wildcard byte pattern scanner: directed and random regions.
`default_nettype none
module wildcard_byte_pattern_scanner_tb;

  localparam int unsigned COUNT_WIDTH   = 32;
  localparam longint unsigned COUNT_TOP = (longint'(1) << COUNT_WIDTH) - 1;
  localparam int unsigned TOP_INDEX     = (1 << wbps_pkg::CFG_INDEX_W) - 1;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned RANDOM_BYTES  = 700;
  localparam int unsigned MIN_REGIONS   = 48;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef enum int unsigned {RK_MATCH, RK_BROKEN, RK_NOISE, RK_SHORT} region_kind_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [7:0]                       data_byte = 8'h00;
  logic                             last_byte = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             found;
  logic [wbps_pkg::ADDR_W-1:0]      match_address;

  wildcard_byte_pattern_scanner u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_address (match_address)
  );

  always #10 clk = ~clk;

  // scanner copy: registers and region state
  logic [63:0]                  cfg_pat_lo = '0;
  logic [63:0]                  cfg_pat_hi = '0;
  logic [15:0]                  cfg_wild = '0;
  logic [wbps_pkg::LEN_W-1:0]   cfg_len = wbps_pkg::LEN_W'(1);
  logic [wbps_pkg::ADDR_W-1:0]  cfg_base = '0;
  logic [7:0]                   scan_window [wbps_pkg::PATTERN_BYTES];
  longint unsigned              scan_count = 0;
  bit                           scan_reported = 1'b0;

  wbps_pkg::res_t         pending_matches [$];
  byte_req_t              bytes_to_send [$];
  int unsigned            mismatches = 0;
  int unsigned            bytes_accepted = 0;
  int unsigned            random_bytes = 0;
  int unsigned            closed_regions = 0;

  function automatic int unsigned eff_len();
    return (cfg_len > wbps_pkg::PATTERN_BYTES) ? wbps_pkg::PATTERN_BYTES : int'(cfg_len);
  endfunction

  function automatic logic [7:0] pattern_at(int unsigned j);
    if (j < 8) return cfg_pat_lo[8*j +: 8];
    if (j < 16) return cfg_pat_hi[8*(j-8) +: 8];
    return 8'h00;
  endfunction

  function automatic bit is_wild(int unsigned j);
    return (j < 16) && cfg_wild[j];
  endfunction

  function automatic void clear_scan();
    scan_window = '{default: 8'h00};
    scan_count = 0;
    scan_reported = 1'b0;
  endfunction

  function automatic void apply_reg(logic [wbps_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] val);
    case (idx)
      wbps_pkg::REG_PATTERN_LOW:    cfg_pat_lo = val;
      wbps_pkg::REG_PATTERN_HIGH:   cfg_pat_hi = val;
      wbps_pkg::REG_WILDCARD_MASK:  cfg_wild = val[15:0];
      wbps_pkg::REG_PATTERN_LENGTH: cfg_len = val[wbps_pkg::LEN_W-1:0];
      wbps_pkg::REG_REGION_BASE:    cfg_base = val;
      default: ;
    endcase
  endfunction

  // Shift in one byte and queue the result it causes, if any.
  function automatic void scan_byte(logic [7:0] b, logic last);
    int unsigned    len;
    int             i;
    bit             counted;
    bit             hit;
    wbps_pkg::res_t r;
    len = eff_len();
    for (i = wbps_pkg::PATTERN_BYTES - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
    scan_window[0] = b;
    counted = 1'b0;
    if (scan_count < COUNT_TOP) begin
      scan_count++;
      counted = 1'b1;
    end
    hit = counted && !scan_reported && len > 0 && scan_count >= len;
    for (i = 0; i < int'(len); i++) begin
      if (!is_wild(i) && scan_window[len-1-i] != pattern_at(i)) hit = 1'b0;
    end
    if (hit) begin
      r.found = 1'b1;
      r.address = cfg_base + 64'(scan_count - len);
      pending_matches.insert(pending_matches.size(), r);
      scan_reported = 1'b1;
      if (last) clear_scan();
    end else if (last) begin
      if (!scan_reported) begin
        r.found = 1'b0;
        r.address = '0;
        pending_matches.insert(pending_matches.size(), r);
      end
      clear_scan();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // request driver: bursts with gaps, occasional hold until all results are in
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          drain_hold = 1'b0;
  byte_req_t   next_req;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_byte(data_byte, last_byte);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (drain_hold && pending_matches.size() == 0) drain_hold = 1'b0;
        if (gap_left != 0 || drain_hold || bytes_to_send.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          next_req = bytes_to_send.pop_front();
          in_valid <= 1'b1;
          data_byte <= next_req.data;
          last_byte <= next_req.last;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
          if ($urandom_range(0, 49) == 0 || bytes_accepted == 100) drain_hold = 1'b1;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  int unsigned    stall_mode = 0;
  int unsigned    stall_span = 0;
  wbps_pkg::res_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b addr=%h",
                                  found, match_address));
      end else begin
        want = pending_matches.pop_front();
        if (found !== want.found)
          report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
        if (match_address !== want.address)
          report_mismatch($sformatf("match_address %h, expected %h",
                                    match_address, want.address));
      end
    end
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(16, 80);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 4) != 0);
      default: out_stall <= stall_span[2];
    endcase
  end

  // watchdog: no progress on any port for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("wildcard_byte_pattern_scanner test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [wbps_pkg::CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    byte_req_t req;
    req.data = b;
    req.last = last;
    bytes_to_send.insert(bytes_to_send.size(), req);
  endtask

  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || in_valid || pending_matches.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic shuffle_config(input bit all_regs);
    logic [63:0] v;
    if (all_regs || $urandom_range(0, 1)) write_reg(wbps_pkg::REG_PATTERN_LOW, pick64());
    if (all_regs || $urandom_range(0, 1)) write_reg(wbps_pkg::REG_PATTERN_HIGH, pick64());
    if (all_regs || $urandom_range(0, 1)) begin
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: v[15:0] = '0;
        1: v[15:0] = '1;
        default: v[15:0] = 16'($urandom & $urandom & $urandom);
      endcase
      write_reg(wbps_pkg::REG_WILDCARD_MASK, v);
    end
    if (all_regs || $urandom_range(0, 1)) begin
      v = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
      case ($urandom_range(0, 11))
        0: v[wbps_pkg::LEN_W-1:0] = '0;
        1: v[wbps_pkg::LEN_W-1:0] = wbps_pkg::LEN_W'(wbps_pkg::PATTERN_BYTES);
        2: v[wbps_pkg::LEN_W-1:0] = wbps_pkg::LEN_W'($urandom_range(
             wbps_pkg::PATTERN_BYTES + 1, (1 << wbps_pkg::LEN_W) - 1));
        3, 4, 5, 6: v[wbps_pkg::LEN_W-1:0] = wbps_pkg::LEN_W'($urandom_range(1, 4));
        default: v[wbps_pkg::LEN_W-1:0] =
          wbps_pkg::LEN_W'($urandom_range(5, wbps_pkg::PATTERN_BYTES - 1));
      endcase
      write_reg(wbps_pkg::REG_PATTERN_LENGTH, v);
    end
    if (all_regs || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 4))
        0: v = '0;
        1: v = '1;
        2: v = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40);
        default: v = {$urandom, $urandom};
      endcase
      write_reg(wbps_pkg::REG_REGION_BASE, v);
    end
    if ($urandom_range(0, 3) == 0)
      write_reg(wbps_pkg::CFG_INDEX_W'($urandom_range(int'(wbps_pkg::REG_REGION_BASE) + 1,
                                                      TOP_INDEX)), pick64());
  endtask

  // Build one region around the current pattern; the last region of a phase
  // may stay open so the next config lands mid-region.
  task automatic queue_region(input region_kind_t kind, input bit leave_open);
    logic [7:0]  body [$];
    int unsigned len;
    int unsigned n;
    int unsigned k;
    len = eff_len();
    case (kind)
      RK_NOISE: begin
        n = $urandom_range(1, 24);
        for (k = 0; k < n; k++) body.insert(body.size(), 8'($urandom));
      end
      RK_SHORT: begin
        n = (len > 1) ? $urandom_range(1, len - 1) : 1;
        for (k = 0; k < n; k++) body.insert(body.size(), 8'($urandom));
      end
      default: begin
        n = $urandom_range(0, 8);
        for (k = 0; k < n; k++) body.insert(body.size(), 8'($urandom));
        for (k = 0; k < len; k++)
          body.insert(body.size(), is_wild(k) ? 8'($urandom) : pattern_at(k));
        if (kind == RK_BROKEN && len != 0) begin
          k = $urandom_range(0, len - 1);
          if (!is_wild(k)) body[n + k] = body[n + k] ^ 8'($urandom_range(1, 255));
        end
        n = $urandom_range(0, 4);
        for (k = 0; k < n; k++) body.insert(body.size(), 8'($urandom));
        if (body.size() == 0) body.insert(body.size(), 8'($urandom));
      end
    endcase
    for (k = 0; k < body.size(); k++) push_byte(body[k], (k == body.size() - 1) && !leave_open);
    random_bytes += body.size();
    if (!leave_open) closed_regions++;
  endtask

  initial begin
    int unsigned  regions;
    int unsigned  r;
    int unsigned  k;
    region_kind_t kind;
    bit           first_phase;
    clear_scan();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset registers: one-byte pattern of zero; match mid-region, then a miss
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // zero length after dropping the upper bits: never matches
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b1);
    wait_idle();

    // oversized length clamps to 16, all positions wild, match on the last byte
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, '1);
    write_reg(wbps_pkg::REG_WILDCARD_MASK, '1);
    write_reg(wbps_pkg::REG_PATTERN_LOW, '1);
    write_reg(wbps_pkg::REG_PATTERN_HIGH, '1);
    write_reg(wbps_pkg::REG_REGION_BASE, '1);
    write_reg(wbps_pkg::CFG_INDEX_W'(TOP_INDEX), '0);
    for (k = 0; k < wbps_pkg::PATTERN_BYTES; k++)
      push_byte(k[0] ? 8'hFF : 8'h00, k == wbps_pkg::PATTERN_BYTES - 1);
    // region shorter than the pattern
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFE, 1'b1);
    wait_idle();

    first_phase = 1'b1;
    while (random_bytes < RANDOM_BYTES || closed_regions < MIN_REGIONS) begin
      shuffle_config(first_phase);
      first_phase = 1'b0;
      regions = $urandom_range(3, 8);
      for (r = 0; r < regions; r++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: kind = RK_MATCH;
          6, 7: kind = RK_BROKEN;
          8: kind = RK_NOISE;
          default: kind = RK_SHORT;
        endcase
        queue_region(kind, (r == regions - 1) && ($urandom_range(0, 9) == 0));
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("wildcard_byte_pattern_scanner test passed");
    end else begin
      $display("wildcard_byte_pattern_scanner test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/wbps_pkg.sv
rtl/core/wbps_cell.sv
rtl/core/wbps_outq.sv
rtl/core/wildcard_byte_pattern_scanner.sv
rtl/core/wbps_checker.sv
tb/sv/wildcard_byte_pattern_scanner_tb.sv
